// ===== rtl/dfpm_pkg.sv =====
// ----------------------------------------------------------------------------
// dfpm_pkg
// Shared types and constants of the driver fault and supply power monitor.
// ----------------------------------------------------------------------------
package dfpm_pkg;

	localparam int NUM_DRIVERS = 3;
	localparam int MAP_W       = 3;
	localparam int LEVEL_W     = 12;
	localparam int CNT_W       = 16;
	localparam int PTR_W       = 2;
	localparam int CFG_IDX_W   = 3;

	localparam logic [PTR_W-1:0] LAST_DRIVER = PTR_W'(NUM_DRIVERS - 1);
	localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ON_LEVEL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_LEVEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEC_EN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REHOME    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAUSE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LOG       = 3'd5;

	// 10.5 V and 10.0 V through the board divider, 3.3 V over 4096 counts
	localparam logic [LEVEL_W-1:0] ON_LEVEL_RST  = 12'd1185;
	localparam logic [LEVEL_W-1:0] OFF_LEVEL_RST = 12'd1128;

	// stall action groups
	localparam int ACT_REHOME = 0;
	localparam int ACT_PAUSE  = 1;
	localparam int ACT_LOG    = 2;

	typedef struct packed {
		logic [LEVEL_W-1:0] on_level;
		logic [LEVEL_W-1:0] off_level;
		logic               sec_en;
		logic [MAP_W-1:0]   rehome_mask;
		logic [MAP_W-1:0]   pause_mask;
		logic [MAP_W-1:0]   log_mask;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] main_lvl;
		logic [LEVEL_W-1:0] sec_lvl;
		logic               ot;
		logic               otpw;
		logic               s2g;
		logic               ola;
		logic               olb;
		logic               sg;
	} item_t;

	typedef struct packed {
		logic                       powered;
		logic [CNT_W-1:0]           loss_cnt;
		logic [PTR_W-1:0]           ptr;
		logic [MAP_W-1:0]           shutdown;
		logic [MAP_W-1:0]           warning;
		logic [MAP_W-1:0]           shorted;
		logic [1:0][MAP_W-1:0]      open_seen;
		logic [1:0][MAP_W-1:0]      open_clr;
		logic [1:0]                 win_run;
		logic [MAP_W-1:0]           stalled;
		logic [2:0][MAP_W-1:0]      act;
	} state_t;

	typedef struct packed {
		logic                       powered;
		logic [CNT_W-1:0]           loss_cnt;
		logic [PTR_W-1:0]           ptr;
		logic [MAP_W-1:0]           shutdown;
		logic [MAP_W-1:0]           warning;
		logic [MAP_W-1:0]           shorted;
		logic [1:0][MAP_W-1:0]      open_seen;
		logic [1:0]                 win_run;
		logic [MAP_W-1:0]           stalled;
		logic [2:0][MAP_W-1:0]      act;
	} result_t;

endpackage

// ===== rtl/driver_fault_power_monitor_core.sv =====
// ----------------------------------------------------------------------------
// driver_fault_power_monitor_core
// Supply presence tracking and round-robin stepper driver fault maps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat per polling tick, carrying the
//   averaged rail readings and the flags of the driver named by the last
//   poll_index. Output channel (out_valid/out_ready): one beat per input beat,
//   the monitor state after that tick.
//   Results are registered. Throughput: one beat per cycle while in_ready is
//   high; the state update is a single pass of compare and bit-set logic from
//   the state registers back into themselves.
//   A two-entry result buffer (output register plus skid register) lets an
//   input beat be taken while one result waits; in_ready drops only when
//   both entries are held by a stalled receiver.
//   Reset clears all maps, the loss count, the poll pointer and the powered
//   flag, and loads the default on/off levels (1185 / 1128 counts).
//   Configuration writes (cfg_we, cfg_index, cfg_data) apply to later beats.
// ----------------------------------------------------------------------------
module driver_fault_power_monitor_core import dfpm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEVEL_W-1:0]   cfg_data,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [LEVEL_W-1:0]   main_rail_level,
	input  logic [LEVEL_W-1:0]   second_rail_level,
	input  logic                 overtemp_flag,
	input  logic                 overtemp_warn_flag,
	input  logic                 short_ground_flag,
	input  logic                 open_phase_a_flag,
	input  logic                 open_phase_b_flag,
	input  logic                 stall_flag,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 supply_present,
	output logic [CNT_W-1:0]     power_loss_count,
	output logic [PTR_W-1:0]     poll_index,
	output logic [MAP_W-1:0]     shutdown_map,
	output logic [MAP_W-1:0]     warning_map,
	output logic [MAP_W-1:0]     short_map,
	output logic [MAP_W-1:0]     open_a_map,
	output logic [MAP_W-1:0]     open_b_map,
	output logic [1:0]           open_windows_active,
	output logic [MAP_W-1:0]     stalled_map,
	output logic [3*MAP_W-1:0]   stall_action_maps
);

	cfg_t    cfg_q;
	item_t   item;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_new;
	result_t main_q;
	result_t skid_q;
	logic    main_v_q;
	logic    skid_v_q;
	logic    push;
	logic    pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_level    <= ON_LEVEL_RST;
			cfg_q.off_level   <= OFF_LEVEL_RST;
			cfg_q.sec_en      <= 1'b0;
			cfg_q.rehome_mask <= '0;
			cfg_q.pause_mask  <= '0;
			cfg_q.log_mask    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ON_LEVEL:  cfg_q.on_level    <= cfg_data;
				CFG_OFF_LEVEL: cfg_q.off_level   <= cfg_data;
				CFG_SEC_EN:    cfg_q.sec_en      <= cfg_data[0];
				CFG_REHOME:    cfg_q.rehome_mask <= cfg_data[MAP_W-1:0];
				CFG_PAUSE:     cfg_q.pause_mask  <= cfg_data[MAP_W-1:0];
				CFG_LOG:       cfg_q.log_mask    <= cfg_data[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	assign item.main_lvl = main_rail_level;
	assign item.sec_lvl  = second_rail_level;
	assign item.ot       = overtemp_flag;
	assign item.otpw     = overtemp_warn_flag;
	assign item.s2g      = short_ground_flag;
	assign item.ola      = open_phase_a_flag;
	assign item.olb      = open_phase_b_flag;
	assign item.sg       = stall_flag;

	dfpm_update u_update (
		.cfg  (cfg_q),
		.item (item),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	assign in_ready = !skid_v_q;
	assign push     = in_valid && in_ready;
	assign pop      = main_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= '0;
		else if (push)
			state_q <= state_nxt;
	end

	assign res_new.powered   = state_nxt.powered;
	assign res_new.loss_cnt  = state_nxt.loss_cnt;
	assign res_new.ptr       = state_nxt.ptr;
	assign res_new.shutdown  = state_nxt.shutdown;
	assign res_new.warning   = state_nxt.warning;
	assign res_new.shorted   = state_nxt.shorted;
	assign res_new.open_seen = state_nxt.open_seen;
	assign res_new.win_run   = state_nxt.win_run;
	assign res_new.stalled   = state_nxt.stalled;
	assign res_new.act       = state_nxt.act;

	// result buffer: main register drives the port, skid catches a beat on stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q)
				skid_v_q <= 1'b0;
			else
				main_v_q <= push;
		end else if (push) begin
			if (!main_v_q)
				main_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q)
				main_q <= skid_q;
			else if (push)
				main_q <= res_new;
		end else if (push) begin
			if (!main_v_q)
				main_q <= res_new;
			else
				skid_q <= res_new;
		end
	end

	assign out_valid           = main_v_q;
	assign supply_present      = main_q.powered;
	assign power_loss_count    = main_q.loss_cnt;
	assign poll_index          = main_q.ptr;
	assign shutdown_map        = main_q.shutdown;
	assign warning_map         = main_q.warning;
	assign short_map           = main_q.shorted;
	assign open_a_map          = main_q.open_seen[0];
	assign open_b_map          = main_q.open_seen[1];
	assign open_windows_active = main_q.win_run;
	assign stalled_map         = main_q.stalled;
	assign stall_action_maps   = main_q.act;

endmodule

// ===== rtl/dfpm_update.sv =====
// ----------------------------------------------------------------------------
// dfpm_update
// Next-state logic for one tick: supply hysteresis, loss count, fault maps.
// ----------------------------------------------------------------------------
module dfpm_update import dfpm_pkg::*; (
	input  cfg_t   cfg,
	input  item_t  item,
	input  state_t cur,
	output state_t nxt
);

	logic on_ok;
	logic off_now;

	function automatic void open_upd(input logic flag, input logic [PTR_W-1:0] p,
			inout logic [MAP_W-1:0] seen, inout logic [MAP_W-1:0] clr,
			inout logic run);
		if (flag) begin
			if (!run) begin
				run  = 1'b1;
				seen = '0;
				clr  = '0;
			end
			seen[p] = 1'b1;
		end else if (run) begin
			clr[p] = 1'b1;
			if ((seen & ~clr) == '0)
				run = 1'b0;
		end
	endfunction

	assign on_ok   = (item.main_lvl >= cfg.on_level) &&
	                 (!cfg.sec_en || item.sec_lvl >= cfg.on_level);
	assign off_now = (item.main_lvl < cfg.off_level) ||
	                 (cfg.sec_en && item.sec_lvl < cfg.off_level);

	always_comb begin
		nxt = cur;
		if (!cur.powered && on_ok) begin
			nxt.powered = 1'b1;
		end else if (cur.powered && off_now) begin
			nxt.powered = 1'b0;
			if (cur.loss_cnt != CNT_MAX)
				nxt.loss_cnt = cur.loss_cnt + 1'b1;
		end else begin
			if (item.ot)
				nxt.shutdown[cur.ptr] = 1'b1;
			else if (item.otpw)
				nxt.warning[cur.ptr] = 1'b1;

			nxt.shorted[cur.ptr] = item.s2g;

			open_upd(item.ola, cur.ptr, nxt.open_seen[0], nxt.open_clr[0], nxt.win_run[0]);
			open_upd(item.olb, cur.ptr, nxt.open_seen[1], nxt.open_clr[1], nxt.win_run[1]);

			if (item.sg && !cur.stalled[cur.ptr]) begin
				if (cfg.rehome_mask[cur.ptr])
					nxt.act[ACT_REHOME][cur.ptr] = 1'b1;
				else if (cfg.pause_mask[cur.ptr])
					nxt.act[ACT_PAUSE][cur.ptr] = 1'b1;
				else if (cfg.log_mask[cur.ptr])
					nxt.act[ACT_LOG][cur.ptr] = 1'b1;
			end
			nxt.stalled[cur.ptr] = item.sg;

			if (cur.ptr >= LAST_DRIVER)
				nxt.ptr = '0;
			else
				nxt.ptr = cur.ptr + 1'b1;
		end
	end

endmodule
